### rtl/core/hcvg_pkg.sv
// Hilbert curve vertex generator: shared types, codes and rule tables.
// Used by hcvg_cell and hilbert_curve_vertex_generator; no dependencies.
`timescale 1ns / 1ps

package hcvg_pkg;

  localparam int COORD_BITS = 16;
  localparam int STEP_BITS  = 10;
  localparam int ORDER_BITS = 4;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_CURVE_ORDER = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_X     = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_Y     = 2'd3;

  localparam logic [ORDER_BITS-1:0] ORDER_RESET = 4'd7;
  localparam logic [STEP_BITS-1:0]  STEP_RESET  = 10'd3;
  localparam logic [COORD_BITS-1:0] START_RESET = 16'd50;

  typedef enum logic [1:0] {
    RULE_A = 2'd0,
    RULE_B = 2'd1,
    RULE_C = 2'd2,
    RULE_D = 2'd3
  } rule_t;

  typedef enum logic [1:0] {
    DIR_PX = 2'd0,
    DIR_NX = 2'd1,
    DIR_PY = 2'd2,
    DIR_NY = 2'd3
  } dir_t;

  typedef logic [2:0] phase_t;
  localparam phase_t PHASE_DONE = 3'd7;

  // What one cell tells its neighbors and the sequencer in a cycle
  typedef struct packed {
    logic  up;    // descend: next level takes the token
    rule_t sub;   // rule handed to the next level
    logic  down;  // level finished: previous level takes the token
    logic  mv;    // a move was found
    dir_t  dir;
  } cell_out_t;

  // Sub-rule called in slot k of a rule
  function automatic rule_t sub_rule(input rule_t r, input logic [1:0] k);
    rule_t res;
    res = RULE_A;
    case (r)
      RULE_A: begin
        case (k)
          2'd0:    res = RULE_D;
          2'd3:    res = RULE_C;
          default: res = RULE_A;
        endcase
      end
      RULE_B: begin
        case (k)
          2'd0:    res = RULE_C;
          2'd3:    res = RULE_D;
          default: res = RULE_B;
        endcase
      end
      RULE_C: begin
        case (k)
          2'd0:    res = RULE_B;
          2'd3:    res = RULE_A;
          default: res = RULE_C;
        endcase
      end
      default: begin
        case (k)
          2'd0:    res = RULE_A;
          2'd3:    res = RULE_B;
          default: res = RULE_D;
        endcase
      end
    endcase
    return res;
  endfunction

  // Move made in slot k (0..2) of a rule
  function automatic dir_t move_dir(input rule_t r, input logic [1:0] k);
    dir_t res;
    res = DIR_PX;
    case (r)
      RULE_A: begin
        case (k)
          2'd0:    res = DIR_PX;
          2'd1:    res = DIR_PY;
          default: res = DIR_NX;
        endcase
      end
      RULE_B: begin
        case (k)
          2'd0:    res = DIR_NX;
          2'd1:    res = DIR_NY;
          default: res = DIR_PX;
        endcase
      end
      RULE_C: begin
        case (k)
          2'd0:    res = DIR_NY;
          2'd1:    res = DIR_NX;
          default: res = DIR_PY;
        endcase
      end
      default: begin
        case (k)
          2'd0:    res = DIR_PY;
          2'd1:    res = DIR_PX;
          default: res = DIR_NY;
        endcase
      end
    endcase
    return res;
  endfunction

endpackage

### rtl/core/hcvg_cell.sv
// One recursion level of the Hilbert walk: rule, phase and the walk token.
// Depends on hcvg_pkg.
`timescale 1ns / 1ps

module hcvg_cell #(
  parameter bit IS_ROOT = 1'b0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              enable,
  input  logic              leaf,
  input  logic              up_in,
  input  hcvg_pkg::rule_t   up_rule,
  input  logic              down_in,
  output hcvg_pkg::cell_out_t cell_out
);

  hcvg_pkg::rule_t  rule;
  hcvg_pkg::phase_t phase;
  logic             token;

  // Decode what this level does when it holds the token
  always_comb begin
    cell_out      = '0;
    cell_out.sub  = hcvg_pkg::sub_rule(rule, phase[2:1]);
    cell_out.dir  = hcvg_pkg::move_dir(rule, phase[2:1]);
    if (enable && token) begin
      if (phase == hcvg_pkg::PHASE_DONE) begin
        cell_out.down = 1'b1;
      end else if (phase[0]) begin
        cell_out.mv = 1'b1;
      end else if (!leaf) begin
        cell_out.up = 1'b1;
      end
    end
  end

  // Level state; only one cell holds the token at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      token <= IS_ROOT;
      rule  <= hcvg_pkg::RULE_A;
      phase <= '0;
    end else if (clear) begin
      token <= IS_ROOT;
      rule  <= hcvg_pkg::RULE_A;
      phase <= '0;
    end else if (enable) begin
      if (token) begin
        if (phase == hcvg_pkg::PHASE_DONE) begin
          token <= 1'b0;
        end else begin
          phase <= phase + 3'd1;
          if (!phase[0] && !leaf) begin
            token <= 1'b0;
          end
        end
      end
      if (up_in) begin
        token <= 1'b1;
        rule  <= up_rule;
        phase <= '0;
      end
      if (down_in) begin
        token <= 1'b1;
      end
    end
  end

endmodule

### rtl/core/hilbert_curve_vertex_generator.sv
// Hilbert curve vertex generator top level: config registers, walk sequencer,
// output register and the chain of level cells. Depends on hcvg_pkg, hcvg_cell.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall, field restart): each accepted item
//   asks for one vertex. restart = 1, or the first item after reset, starts
//   the curve and returns the start point. restart = 0 returns the next vertex.
//   Output channel (out_valid / out_stall): one item per input item, with
//   point_x, point_y and final_point. After the last vertex of the 4^order
//   points, further items repeat it with final_point set.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready;
//   write it while no item is in flight. Order is latched at curve start.
// Sequencing:
//   Start points and repeated final vertices are registered on accept and
//   appear in the cycle after it. A move is found as the token steps level
//   by level through the cell chain, unwinding finished levels or descending
//   to the leaf level. One item is in flight at a time.
// Reset clears the walk; configuration returns to order 7, step 3, start
// (50, 50). While the output register is full and stalled, in_stall is high.
module hilbert_curve_vertex_generator #(
  parameter int MAX_ORDER = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hcvg_pkg::COORD_BITS-1:0]     point_x,
  output logic [hcvg_pkg::COORD_BITS-1:0]     point_y,
  output logic                                final_point,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hcvg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hcvg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int AO_BITS   = $clog2(MAX_ORDER + 1);
  localparam int MOVE_BITS = 2 * MAX_ORDER;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  // Configuration registers
  logic [hcvg_pkg::ORDER_BITS-1:0] curve_order;
  logic [hcvg_pkg::STEP_BITS-1:0]  step_length;
  logic [hcvg_pkg::COORD_BITS-1:0] start_x;
  logic [hcvg_pkg::COORD_BITS-1:0] start_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_order <= hcvg_pkg::ORDER_RESET;
      step_length <= hcvg_pkg::STEP_RESET;
      start_x     <= hcvg_pkg::START_RESET;
      start_y     <= hcvg_pkg::START_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hcvg_pkg::REG_CURVE_ORDER: curve_order <= cfg_data[hcvg_pkg::ORDER_BITS-1:0];
        hcvg_pkg::REG_STEP_LENGTH: step_length <= cfg_data[hcvg_pkg::STEP_BITS-1:0];
        hcvg_pkg::REG_START_X:     start_x     <= cfg_data;
        hcvg_pkg::REG_START_Y:     start_y     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state
  state_t                          state;
  logic                            started;
  logic [AO_BITS-1:0]              active_order;
  logic [MOVE_BITS-1:0]            moves_left;
  logic [hcvg_pkg::COORD_BITS-1:0] current_x;
  logic [hcvg_pkg::COORD_BITS-1:0] current_y;

  logic                            in_fire;
  logic                            out_free;
  logic                            begin_walk;
  logic                            walking;
  logic [AO_BITS-1:0]              active_order_next;
  logic [MOVE_BITS-1:0]            moves_init;
  logic [MOVE_BITS-1:0]            moves_left_next;
  logic [hcvg_pkg::COORD_BITS-1:0] x_next;
  logic [hcvg_pkg::COORD_BITS-1:0] y_next;
  logic [hcvg_pkg::COORD_BITS-1:0] step_ext;

  hcvg_pkg::cell_out_t cell_outs [MAX_ORDER];
  logic                found_mv;
  hcvg_pkg::dir_t      found_dir;

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != ST_IDLE) || !out_free;
  assign in_fire    = in_valid && !in_stall;
  assign begin_walk = in_fire && (restart || !started);
  assign walking    = (state == ST_WALK);

  // Clamp the order into 1..MAX_ORDER
  always_comb begin
    if (curve_order == '0) begin
      active_order_next = AO_BITS'(1);
    end else if (int'(curve_order) > MAX_ORDER) begin
      active_order_next = AO_BITS'(MAX_ORDER);
    end else begin
      active_order_next = AO_BITS'(curve_order);
    end
  end

  // 4^order - 1 moves: the low 2*order bits set
  always_comb begin
    for (int j = 0; j < MOVE_BITS; j++) begin
      moves_init[j] = (j < 2 * int'(active_order_next));
    end
  end

  // Level cells, token handed up and down the chain
  for (genvar i = 0; i < MAX_ORDER; i++) begin : g_cell
    logic            leaf;
    logic            up_in;
    hcvg_pkg::rule_t up_rule;
    logic            down_in;

    assign leaf = (active_order == AO_BITS'(i + 1)) || (i == MAX_ORDER - 1);

    if (i == 0) begin : g_first
      assign up_in   = 1'b0;
      assign up_rule = hcvg_pkg::RULE_A;
    end else begin : g_mid
      assign up_in   = cell_outs[i-1].up;
      assign up_rule = cell_outs[i-1].sub;
    end

    if (i == MAX_ORDER - 1) begin : g_last
      assign down_in = 1'b0;
    end else begin : g_inner
      assign down_in = cell_outs[i+1].down;
    end

    hcvg_cell #(
      .IS_ROOT (i == 0)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (begin_walk),
      .enable   (walking),
      .leaf     (leaf),
      .up_in    (up_in),
      .up_rule  (up_rule),
      .down_in  (down_in),
      .cell_out (cell_outs[i])
    );
  end

  // Gather the move from whichever cell holds the token
  always_comb begin
    found_mv  = 1'b0;
    found_dir = hcvg_pkg::DIR_PX;
    for (int i = 0; i < MAX_ORDER; i++) begin
      found_mv  = found_mv | cell_outs[i].mv;
      found_dir = hcvg_pkg::dir_t'(found_dir | ({2{cell_outs[i].mv}} & cell_outs[i].dir));
    end
  end

  // Apply one move
  assign step_ext        = hcvg_pkg::COORD_BITS'(step_length);
  assign moves_left_next = moves_left - MOVE_BITS'(1);

  always_comb begin
    x_next = current_x;
    y_next = current_y;
    case (found_dir)
      hcvg_pkg::DIR_PX: x_next = current_x + step_ext;
      hcvg_pkg::DIR_NX: x_next = current_x - step_ext;
      hcvg_pkg::DIR_PY: y_next = current_y + step_ext;
      hcvg_pkg::DIR_NY: y_next = current_y - step_ext;
      default: ;
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      started      <= 1'b0;
      out_valid    <= 1'b0;
      active_order <= AO_BITS'(1);
      moves_left   <= '0;
      current_x    <= hcvg_pkg::START_RESET;
      current_y    <= hcvg_pkg::START_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (begin_walk) begin
            started      <= 1'b1;
            active_order <= active_order_next;
            moves_left   <= moves_init;
            current_x    <= start_x;
            current_y    <= start_y;
            out_valid    <= 1'b1;
            point_x      <= start_x;
            point_y      <= start_y;
            final_point  <= (moves_init == '0);
          end else if (in_fire) begin
            if (moves_left != '0) begin
              state <= ST_WALK;
            end else begin
              out_valid   <= 1'b1;
              point_x     <= current_x;
              point_y     <= current_y;
              final_point <= 1'b1;
            end
          end
        end
        ST_WALK: begin
          if (found_mv) begin
            state       <= ST_IDLE;
            current_x   <= x_next;
            current_y   <= y_next;
            moves_left  <= moves_left_next;
            out_valid   <= 1'b1;
            point_x     <= x_next;
            point_y     <= y_next;
            final_point <= (moves_left_next == '0);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### tb/sv/hcvg_vertex_checker.sv
// Vertex checker for the Hilbert curve vertex generator: tracks config writes,
// predicts each vertex from its own curve walk and compares the output items.
// Depends on hcvg_pkg for widths, register indexes, reset values and enums.
`timescale 1ns / 1ps

module hcvg_vertex_checker #(
  parameter int MAX_ORDER = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                restart,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [hcvg_pkg::COORD_BITS-1:0]     point_x,
  input  logic [hcvg_pkg::COORD_BITS-1:0]     point_y,
  input  logic                                final_point,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [hcvg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hcvg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  due_count,
  output int                                  vertices_checked,
  output int                                  finals_checked,
  output int                                  curve_starts
);
  import hcvg_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  fin;
  } vertex_t;

  vertex_t vertex_due_q[$];
  vertex_t due_v;

  // Shadow copy of the configuration registers
  logic [ORDER_BITS-1:0] order_reg;
  logic [STEP_BITS-1:0]  step_reg;
  logic [COORD_BITS-1:0] origin_x;
  logic [COORD_BITS-1:0] origin_y;

  // Walk state: one (rule, phase) pair per level
  rule_t                 rule_stk [MAX_ORDER];
  phase_t                phase_stk [MAX_ORDER];
  int                    level;
  int                    act_order;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic                  started;
  logic                  walk_done;
  longint                moves_left;

  // First slot swaps A<->D and B<->C, last slot swaps A<->C and B<->D
  function automatic rule_t child_rule(input rule_t r, input logic [1:0] slot);
    case (slot)
      2'd0:    return rule_t'(r ^ 2'b11);
      2'd3:    return rule_t'(r ^ 2'b10);
      default: return r;
    endcase
  endfunction

  // First move of a rule is the Gray code of the rule (A:+x B:-x C:-y D:+y),
  // the second turns to the other axis, the third reverses the first.
  function automatic dir_t rule_move(input rule_t r, input logic [1:0] slot);
    logic [1:0] first;
    first = r ^ (r >> 1);
    case (slot)
      2'd0:    return dir_t'(first);
      2'd1:    return dir_t'(first ^ 2'b10);
      default: return dir_t'(first ^ 2'b01);
    endcase
  endfunction

  task automatic start_walk();
    for (int k = 0; k < MAX_ORDER; k++) begin
      rule_stk[k]  = RULE_A;
      phase_stk[k] = '0;
    end
    level      = 0;
    act_order  = (order_reg == 0) ? 1 : ((order_reg > MAX_ORDER) ? MAX_ORDER : order_reg);
    cur_x      = origin_x;
    cur_y      = origin_y;
    moves_left = (64'd1 << (2 * act_order)) - 1;
    started    = 1'b1;
    walk_done  = 1'b0;
    curve_starts++;
  endtask

  // Unwind finished levels and descend until a move slot turns up
  task automatic find_move(output logic found, output dir_t d);
    int     lv;
    phase_t ph;
    rule_t  r;
    found = 1'b0;
    d     = DIR_PX;
    for (int guard = 0; guard < 64 * MAX_ORDER; guard++) begin
      lv = level;
      if (lv >= MAX_ORDER) return;
      ph = phase_stk[lv];
      r  = rule_stk[lv];
      if (ph == PHASE_DONE) begin
        if (lv == 0) return;
        level = lv - 1;
        continue;
      end
      phase_stk[lv] = ph + 3'd1;
      if (ph[0]) begin
        d     = rule_move(r, ph[2:1]);
        found = 1'b1;
        return;
      end
      if (act_order - lv > 1 && lv + 1 < MAX_ORDER) begin
        level             = lv + 1;
        rule_stk[lv + 1]  = child_rule(r, ph[2:1]);
        phase_stk[lv + 1] = '0;
      end
    end
  endtask

  task automatic predict_vertex(input logic restart_bit);
    logic    found;
    dir_t    d;
    vertex_t v;
    if (restart_bit || !started) begin
      start_walk();
    end else if (!walk_done && moves_left > 0) begin
      find_move(found, d);
      if (!found) begin
        moves_left = 1;
      end else begin
        case (d)
          DIR_PX:  cur_x = cur_x + step_reg;
          DIR_NX:  cur_x = cur_x - step_reg;
          DIR_PY:  cur_y = cur_y + step_reg;
          default: cur_y = cur_y - step_reg;
        endcase
      end
      moves_left--;
    end
    if (moves_left == 0) walk_done = 1'b1;
    v.x   = cur_x;
    v.y   = cur_y;
    v.fin = walk_done;
    vertex_due_q.push_back(v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      order_reg  = ORDER_RESET;
      step_reg   = STEP_RESET;
      origin_x   = START_RESET;
      origin_y   = START_RESET;
      for (int k = 0; k < MAX_ORDER; k++) begin
        rule_stk[k]  = RULE_A;
        phase_stk[k] = '0;
      end
      level      = 0;
      act_order  = 1;
      cur_x      = START_RESET;
      cur_y      = START_RESET;
      started    = 1'b0;
      walk_done  = 1'b0;
      moves_left = 0;
      vertex_due_q.delete();
      fail_count       = 0;
      due_count        = 0;
      vertices_checked = 0;
      finals_checked   = 0;
      curve_starts     = 0;
    end else begin
      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CURVE_ORDER: order_reg = cfg_data[ORDER_BITS-1:0];
          REG_STEP_LENGTH: step_reg  = cfg_data[STEP_BITS-1:0];
          REG_START_X:     origin_x  = cfg_data[COORD_BITS-1:0];
          default:         origin_y  = cfg_data[COORD_BITS-1:0];
        endcase
      end

      // Output items against the oldest expected vertex
      if (out_valid && !out_stall) begin
        if (vertex_due_q.size() == 0) begin
          $error("vertex (%0d, %0d) arrived with none expected", point_x, point_y);
          fail_count++;
        end else begin
          due_v = vertex_due_q.pop_front();
          if (point_x !== due_v.x) begin
            $error("point_x: expected %0d, got %0d", due_v.x, point_x);
            fail_count++;
          end
          if (point_y !== due_v.y) begin
            $error("point_y: expected %0d, got %0d", due_v.y, point_y);
            fail_count++;
          end
          if (final_point !== due_v.fin) begin
            $error("final_point: expected %0d, got %0d", due_v.fin, final_point);
            fail_count++;
          end
          vertices_checked++;
          if (due_v.fin) finals_checked++;
        end
      end

      // Input items advance the walk
      if (in_valid && !in_stall) predict_vertex(restart);
      due_count = vertex_due_q.size();
    end
  end

endmodule

### tb/sv/testbench.sv
// Top of the Hilbert curve vertex generator testbench: clock, reset, stimulus,
// receiver stalls and the verdict. Depends on hcvg_pkg, hcvg_vertex_checker
// and the hilbert_curve_vertex_generator RTL.
`timescale 1ns / 1ps

module testbench;
  import hcvg_pkg::*;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      restart   = 1'b0;
  logic                      out_stall = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_CURVE_ORDER;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      in_stall;
  logic                      out_valid;
  logic [COORD_BITS-1:0]     point_x;
  logic [COORD_BITS-1:0]     point_y;
  logic                      final_point;
  logic                      cfg_ready;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_req       = 1'b0;
  int   hold_left      = 0;
  int   requests_sent  = 0;

  int fail_count;
  int due_count;
  int vertices_checked;
  int finals_checked;
  int curve_starts;

  always #5 clk = ~clk;

  hilbert_curve_vertex_generator DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .final_point (final_point),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  hcvg_vertex_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .restart          (restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .point_x          (point_x),
    .point_y          (point_y),
    .final_point      (final_point),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .due_count        (due_count),
    .vertices_checked (vertices_checked),
    .finals_checked   (finals_checked),
    .curve_starts     (curve_starts)
  );

  // Receiver: random stalls plus one long hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_left != 0) hold_left <= hold_left - 1;
      else if (hold_req) hold_left <= 300;
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct  = sender_pct;
    recv_stall_pct <= receiver_pct;
  endtask

  // One vertex request, with a random gap in front of it
  task automatic send_vertex_req(input logic restart_bit);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= restart_bit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] order_word, input logic [15:0] step_word,
                              input logic [15:0] sx, input logic [15:0] sy);
    write_reg(REG_CURVE_ORDER, order_word);
    write_reg(REG_STEP_LENGTH, step_word);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    cfg_valid <= 1'b0;
  endtask

  // Drain every expected vertex, then give the cell chain time to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [3:0]  order_pick;
    logic [9:0]  step_pick;
    logic [31:0] junk;
    int          ord_eff;
    int          walk_len;
    int          n;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First item after reset starts the curve even with restart low
    send_vertex_req(1'b0);
    repeat (3) send_vertex_req(1'b0);
    settle();

    // Order changed mid-curve: old order 7 keeps going, new step applies
    program_regs(16'd1, 16'd1023, 16'hFFFF, 16'h0000);
    repeat (2) send_vertex_req(1'b0);
    // Order-1 curve from the corner, wrapping x; two repeats of the last vertex
    send_vertex_req(1'b1);
    repeat (5) send_vertex_req(1'b0);
    settle();

    // Order 0 counts as 1, zero step
    program_regs(16'd0, 16'd0, 16'h0000, 16'hFFFF);
    send_vertex_req(1'b1);
    repeat (4) send_vertex_req(1'b0);
    settle();

    // Order above the maximum saturates
    program_regs(16'd15, 16'd1, 16'h0000, 16'h0000);
    send_vertex_req(1'b1);
    repeat (2) send_vertex_req(1'b0);
    settle();

    // Step and start changed mid-curve; start only used after restart
    program_regs(16'd15, 16'd512, 16'd1234, 16'd40000);
    repeat (2) send_vertex_req(1'b0);
    send_vertex_req(1'b1);
    send_vertex_req(1'b0);

    // Random phases: mostly small curves walked to the end, some noise restarts
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p % 4)
        0:       set_idling(0, 0);
        1:       set_idling(68, 0);
        2:       set_idling(0, 68);
        default: set_idling(15, 15);
      endcase
      order_pick = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 3));
      case ($urandom_range(0, 5))
        0:       step_pick = '0;
        1:       step_pick = '1;
        default: step_pick = 10'($urandom_range(0, 1023));
      endcase
      junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      program_regs({junk[11:0], order_pick}, {junk[21:16], step_pick},
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      ord_eff = (order_pick == 0) ? 1 : ((order_pick > 8) ? 8 : order_pick);
      n = 0;
      while (n < 50) begin
        walk_len = (ord_eff <= 3) ? (1 << (2 * ord_eff)) + $urandom_range(0, 3)
                                  : $urandom_range(8, 48);
        send_vertex_req(1'b1);
        n++;
        for (int k = 1; k < walk_len && n < 50; k++) begin
          send_vertex_req($urandom_range(0, 29) == 0);
          n++;
        end
      end
    end

    // Long output hold-off while requests keep coming, so the input backs up
    settle();
    set_idling(0, 0);
    program_regs(16'd8, 16'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
    hold_req <= 1'b1;
    send_vertex_req(1'b1);
    hold_req <= 1'b0;
    repeat (29) send_vertex_req(1'b0);

    settle();
    $display("Sent %0d vertex requests; checked %0d vertices, %0d curve starts, %0d final",
             requests_sent, vertices_checked, curve_starts, finals_checked);
    $display("Orders 0..15, step and coordinate extremes, four idle mixes, one long hold");
    if (fail_count == 0 && due_count == 0) begin
      $display("PASS hilbert_curve_vertex_generator");
    end else begin
      if (due_count != 0) $error("%0d expected vertices never arrived", due_count);
      $display("FAIL hilbert_curve_vertex_generator");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("FAIL hilbert_curve_vertex_generator");
    $finish;
  end

endmodule
